### hw/rtl/rma_pkg.sv
// ----------------------------------------------------------------------------
// rma_pkg
// Shared constants, operation codes and word types of the RNS modular ALU.
// ----------------------------------------------------------------------------
package rma_pkg;

    localparam int NUM_LANES         = 4;
    localparam int DATA_W            = 32;
    localparam int SCALAR_W          = 64;
    localparam int OP_W              = 3;
    localparam int DEF_RESIDUE_BITS  = 32;
    // byte address of the APB port: lane index above the word offset
    localparam int ADDR_W            = $clog2(NUM_LANES) + 2;
    // quotient bits resolved per reduction stage
    localparam int RED_BPS           = 4;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_ADDS = 3'd3;
    localparam logic [OP_W-1:0] OP_MULS = 3'd4;
    localparam logic [OP_W-1:0] OP_LDS  = 3'd5;

    localparam logic [DATA_W-1:0] RESET_MODULI [NUM_LANES] = '{
        32'd4294967291, 32'd4294967279, 32'd4294967231, 32'd4294967197
    };

    typedef struct packed {
        logic [OP_W-1:0]     req_type;
        logic [DATA_W-1:0]   a_lane0;
        logic [DATA_W-1:0]   a_lane1;
        logic [DATA_W-1:0]   a_lane2;
        logic [DATA_W-1:0]   a_lane3;
        logic [DATA_W-1:0]   b_lane0;
        logic [DATA_W-1:0]   b_lane1;
        logic [DATA_W-1:0]   b_lane2;
        logic [DATA_W-1:0]   b_lane3;
        logic [SCALAR_W-1:0] scalar;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] r_lane0;
        logic [DATA_W-1:0] r_lane1;
        logic [DATA_W-1:0] r_lane2;
        logic [DATA_W-1:0] r_lane3;
        logic              bad_input;
    } t_rsp;

endpackage

### hw/rtl/rma_reduce.sv
// ----------------------------------------------------------------------------
// rma_reduce
// Pipelined remainder of an IN_W-bit value by a RES_W-bit modulus, restoring
// long division, RED_BPS quotient bits per register stage.
// ----------------------------------------------------------------------------
module rma_reduce #(
    parameter int IN_W  = 64,
    parameter int RES_W = 32
) (
    input  logic             i_clk,
    input  logic [IN_W-1:0]  i_x,
    input  logic [RES_W-1:0] i_m,
    output logic [RES_W-1:0] o_r
);

    localparam int BPS   = rma_pkg::RED_BPS;
    localparam int NSTG  = (IN_W + BPS - 1) / BPS;
    localparam int PAD_W = NSTG * BPS;

    logic [RES_W-1:0] r_rem [NSTG];
    logic [PAD_W-1:0] r_x   [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic [RES_W-1:0] rem_in;
        logic [PAD_W-1:0] x_in;
        logic [RES_W-1:0] n_rem;
        logic [PAD_W-1:0] n_x;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign x_in   = PAD_W'(i_x);
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign x_in   = r_x[k-1];
        end

        always_comb begin
            logic [RES_W:0]   t;
            logic [RES_W-1:0] rem;
            rem = rem_in;
            for (int j = 0; j < BPS; j++) begin
                // shift in the next dividend bit, subtract once if it fits
                t = {rem, x_in[PAD_W-1-j]};
                if (t >= {1'b0, i_m}) begin
                    t = t - {1'b0, i_m};
                end
                rem = t[RES_W-1:0];
            end
            n_rem = rem;
            n_x   = x_in << BPS;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_x[k]   <= n_x;
        end
    end

    assign o_r = r_rem[NSTG-1];

endmodule

### hw/rtl/rma_lane.sv
// ----------------------------------------------------------------------------
// rma_lane
// One residue lane: scalar reduction, multiply, product reduction and the
// final add/subtract/select stage, with the operands carried alongside.
// ----------------------------------------------------------------------------
module rma_lane #(
    parameter int RESIDUE_BITS = rma_pkg::DEF_RESIDUE_BITS
) (
    input  logic                          i_clk,
    input  logic [rma_pkg::OP_W-1:0]      i_op,
    input  logic [RESIDUE_BITS-1:0]       i_a,
    input  logic [RESIDUE_BITS-1:0]       i_b,
    input  logic [rma_pkg::SCALAR_W-1:0]  i_s,
    input  logic [RESIDUE_BITS-1:0]       i_m,
    output logic [RESIDUE_BITS-1:0]       o_r,
    output logic                          o_bad
);

    localparam int W   = RESIDUE_BITS;
    localparam int BPS = rma_pkg::RED_BPS;
    localparam int NS  = (rma_pkg::SCALAR_W + BPS - 1) / BPS;
    localparam int NP  = (2 * W + BPS - 1) / BPS;

    typedef struct packed {
        logic [rma_pkg::OP_W-1:0] op;
        logic [W-1:0]             a;
        logic [W-1:0]             b;
        logic                     bad;
        logic                     zero;
    } t_side;

    typedef struct packed {
        t_side        base;
        logic [W-1:0] sr;
    } t_side2;

    t_side          n_side;
    t_side          r_side1 [NS];
    t_side2         r_side2 [NP+1];
    logic [W-1:0]   w_sr;
    logic [W-1:0]   w_pr;
    logic [2*W-1:0] r_prod;
    logic [W-1:0]   r_res;
    logic           r_bad;

    // classify the operation and check the residues it uses
    always_comb begin
        logic use_a;
        logic use_b;
        logic op_ok;
        logic bad;
        use_a = 1'b0;
        use_b = 1'b0;
        op_ok = 1'b1;
        case (i_op) inside
            rma_pkg::OP_ADD, rma_pkg::OP_SUB, rma_pkg::OP_MUL: begin
                use_a = 1'b1;
                use_b = 1'b1;
            end
            rma_pkg::OP_ADDS, rma_pkg::OP_MULS: begin
                use_a = 1'b1;
            end
            rma_pkg::OP_LDS: begin
                use_a = 1'b0;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
        bad = op_ok && ((i_m == '0) || (use_a && (i_a >= i_m)) || (use_b && (i_b >= i_m)));
        n_side.op   = i_op;
        n_side.a    = i_a;
        n_side.b    = i_b;
        n_side.bad  = bad;
        n_side.zero = bad || !op_ok;
    end

    rma_reduce #(
        .IN_W  (rma_pkg::SCALAR_W),
        .RES_W (W)
    ) u_red_scalar (
        .i_clk (i_clk),
        .i_x   (i_s),
        .i_m   (i_m),
        .o_r   (w_sr)
    );

    always_ff @(posedge i_clk) begin
        r_side1[0] <= n_side;
        for (int k = 1; k < NS; k++) begin
            r_side1[k] <= r_side1[k-1];
        end
    end

    // multiply stage: b for multiply, reduced scalar otherwise
    always_ff @(posedge i_clk) begin
        if (r_side1[NS-1].op == rma_pkg::OP_MUL) begin
            r_prod <= r_side1[NS-1].a * r_side1[NS-1].b;
        end else begin
            r_prod <= r_side1[NS-1].a * w_sr;
        end
        r_side2[0].base <= r_side1[NS-1];
        r_side2[0].sr   <= w_sr;
        for (int k = 1; k <= NP; k++) begin
            r_side2[k] <= r_side2[k-1];
        end
    end

    rma_reduce #(
        .IN_W  (2 * W),
        .RES_W (W)
    ) u_red_prod (
        .i_clk (i_clk),
        .i_x   (r_prod),
        .i_m   (i_m),
        .o_r   (w_pr)
    );

    always_ff @(posedge i_clk) begin
        logic [W:0]   sum;
        logic [W-1:0] addend;
        t_side2       sd;
        sd     = r_side2[NP];
        addend = (sd.base.op == rma_pkg::OP_ADD) ? sd.base.b : sd.sr;
        sum    = {1'b0, sd.base.a} + {1'b0, addend};
        if (sum >= {1'b0, i_m}) begin
            sum = sum - {1'b0, i_m};
        end
        if (sd.base.zero) begin
            r_res <= '0;
        end else begin
            case (sd.base.op)
                rma_pkg::OP_ADD, rma_pkg::OP_ADDS: r_res <= sum[W-1:0];
                rma_pkg::OP_SUB: begin
                    // wrap below zero by adding the modulus back
                    if (sd.base.a >= sd.base.b) begin
                        r_res <= sd.base.a - sd.base.b;
                    end else begin
                        r_res <= sd.base.a - sd.base.b + i_m;
                    end
                end
                rma_pkg::OP_MUL, rma_pkg::OP_MULS: r_res <= w_pr;
                rma_pkg::OP_LDS: r_res <= sd.sr;
                default: r_res <= '0;
            endcase
        end
        r_bad <= sd.base.bad;
    end

    assign o_r   = r_res;
    assign o_bad = r_bad;

endmodule

### hw/rtl/rns_modular_alu.sv
// ----------------------------------------------------------------------------
// rns_modular_alu
// Four-lane residue-number-system ALU with per-lane moduli set over APB.
// ----------------------------------------------------------------------------
// A word issued with start appears on o_rsp with o_done high after passing
// the input word register, each lane's pipeline and the output register, and a
// new word may be issued every cycle; busy stays low. Each lane holds two
// remainder pipelines, which resolve four quotient bits per stage: one for
// the 64-bit scalar, one for the product. Results are shown for a single
// cycle and must be taken then.
// Moduli may only be rewritten while no word is in flight.
module rns_modular_alu #(
    parameter int RESIDUE_BITS = rma_pkg::DEF_RESIDUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rma_pkg::t_req                     i_req,
    output logic                              o_done,
    output rma_pkg::t_rsp                     o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rma_pkg::ADDR_W-1:0]        paddr,
    input  logic [rma_pkg::DATA_W-1:0]        pwdata,
    output logic [rma_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int NL       = rma_pkg::NUM_LANES;
    localparam int W        = RESIDUE_BITS;
    localparam int IDX_W    = $clog2(rma_pkg::NUM_LANES);
    localparam int BPS      = rma_pkg::RED_BPS;
    localparam int LANE_LAT = (rma_pkg::SCALAR_W + BPS - 1) / BPS
                              + (2 * RESIDUE_BITS + BPS - 1) / BPS + 2;

    logic [W-1:0]          r_mod [NL];
    rma_pkg::t_req         r_req;
    logic                  r_req_vld;
    logic [LANE_LAT-1:0]   r_vld_pipe;
    rma_pkg::t_rsp         r_rsp;
    logic                  r_done;
    logic [IDX_W-1:0]      w_idx;
    logic [W-1:0]          w_a   [NL];
    logic [W-1:0]          w_b   [NL];
    logic [W-1:0]          w_r   [NL];
    logic [NL-1:0]         w_bad;

    // configuration port
    assign pready = 1'b1;
    assign w_idx  = paddr[rma_pkg::ADDR_W-1:2];
    assign prdata = rma_pkg::DATA_W'(r_mod[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NL; i++) begin
                r_mod[i] <= rma_pkg::RESET_MODULI[i][W-1:0];
            end
        end else if (psel && penable && pwrite) begin
            r_mod[w_idx] <= pwdata[W-1:0];
        end
    end

    assign busy = 1'b0;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
        r_req <= i_req;
    end

    assign w_a[0] = r_req.a_lane0[W-1:0];
    assign w_a[1] = r_req.a_lane1[W-1:0];
    assign w_a[2] = r_req.a_lane2[W-1:0];
    assign w_a[3] = r_req.a_lane3[W-1:0];
    assign w_b[0] = r_req.b_lane0[W-1:0];
    assign w_b[1] = r_req.b_lane1[W-1:0];
    assign w_b[2] = r_req.b_lane2[W-1:0];
    assign w_b[3] = r_req.b_lane3[W-1:0];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        rma_lane #(
            .RESIDUE_BITS (W)
        ) u_lane (
            .i_clk (i_clk),
            .i_op  (r_req.req_type),
            .i_a   (w_a[i]),
            .i_b   (w_b[i]),
            .i_s   (r_req.scalar),
            .i_m   (r_mod[i]),
            .o_r   (w_r[i]),
            .o_bad (w_bad[i])
        );
    end

    // advance valid alongside the lane pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
            r_done     <= 1'b0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[LANE_LAT-2:0], r_req_vld};
            r_done     <= r_vld_pipe[LANE_LAT-1];
        end
        r_rsp.r_lane0   <= rma_pkg::DATA_W'(w_r[0]);
        r_rsp.r_lane1   <= rma_pkg::DATA_W'(w_r[1]);
        r_rsp.r_lane2   <= rma_pkg::DATA_W'(w_r[2]);
        r_rsp.r_lane3   <= rma_pkg::DATA_W'(w_r[3]);
        r_rsp.bad_input <= |w_bad;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_req_vld, LANE_LAT + 1))
        else $error("result word without a matching issued word");

    a_residue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_rsp.bad_input) |->
            (r_rsp.r_lane0 < rma_pkg::DATA_W'(r_mod[0])) &&
            (r_rsp.r_lane1 < rma_pkg::DATA_W'(r_mod[1])) &&
            (r_rsp.r_lane2 < rma_pkg::DATA_W'(r_mod[2])) &&
            (r_rsp.r_lane3 < rma_pkg::DATA_W'(r_mod[3])))
        else $error("clean result residue not below its modulus");

endmodule

### tb/rma_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rma_checker
// Watches the request, result and APB channels of the RNS modular ALU,
// predicts every result word from the accepted request and the moduli
// written so far, and compares it with what the block returns.
// ----------------------------------------------------------------------------
module rma_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  rma_pkg::t_req              i_req,
    input  logic                       i_done,
    input  rma_pkg::t_rsp              i_rsp,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [3:0]                 i_paddr,
    input  logic [rma_pkg::DATA_W-1:0] i_pwdata,
    input  logic                       i_pready,
    output int                         o_errors,
    output int                         o_pending
);
    import rma_pkg::*;

    logic [DATA_W-1:0] lane_moduli [NUM_LANES];
    t_rsp              expected_words [$];

    function automatic logic [DATA_W-1:0] lane_result(input logic [OP_W-1:0] op,
            input logic [63:0] m, input logic [63:0] a, input logic [63:0] b,
            input logic [63:0] s, inout logic bad);
        logic       use_a;
        logic       use_b;
        logic [63:0] t;
        use_a = (op <= OP_MULS);
        use_b = (op <= OP_MUL);
        if (op > OP_LDS) return '0;
        if (m == 0) begin
            bad = 1'b1;
            return '0;
        end
        if ((use_a && a >= m) || (use_b && b >= m)) begin
            bad = 1'b1;
            return '0;
        end
        case (op)
            OP_ADD: begin
                t = a + b;
                return (t >= m) ? t - m : t;
            end
            OP_SUB:  return (a >= b) ? a - b : m + a - b;
            OP_MUL:  return (a * b) % m;
            OP_ADDS: begin
                t = a + (s % m);
                return (t >= m) ? t - m : t;
            end
            OP_MULS: return (a * (s % m)) % m;
            default: return s % m;
        endcase
    endfunction

    function automatic t_rsp predict_residues(input t_req req);
        t_rsp              w;
        logic              bad;
        logic [DATA_W-1:0] a [NUM_LANES];
        logic [DATA_W-1:0] b [NUM_LANES];
        logic [DATA_W-1:0] r [NUM_LANES];
        bad = 1'b0;
        a = '{req.a_lane0, req.a_lane1, req.a_lane2, req.a_lane3};
        b = '{req.b_lane0, req.b_lane1, req.b_lane2, req.b_lane3};
        for (int i = 0; i < NUM_LANES; i++)
            r[i] = lane_result(req.req_type, {32'd0, lane_moduli[i]}, {32'd0, a[i]},
                               {32'd0, b[i]}, req.scalar, bad);
        w.r_lane0   = r[0];
        w.r_lane1   = r[1];
        w.r_lane2   = r[2];
        w.r_lane3   = r[3];
        w.bad_input = bad;
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    assign o_pending = expected_words.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LANES; i++) lane_moduli[i] = RESET_MODULI[i];
        end else begin
            if (i_done) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h", $time, i_rsp);
                    o_errors++;
                end else begin
                    e = expected_words.pop_front();
                    compare_field("r_lane0", e.r_lane0, i_rsp.r_lane0);
                    compare_field("r_lane1", e.r_lane1, i_rsp.r_lane1);
                    compare_field("r_lane2", e.r_lane2, i_rsp.r_lane2);
                    compare_field("r_lane3", e.r_lane3, i_rsp.r_lane3);
                    compare_field("bad_input", e.bad_input, i_rsp.bad_input);
                end
            end
            if (i_start && !i_busy) expected_words.push_back(predict_residues(i_req));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[3:2] < NUM_LANES)
                lane_moduli[i_paddr[3:2]] = i_pwdata;
        end
    end
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random request words into the RNS modular ALU across
// several modulus settings, with bursty issue, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import rma_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
    localparam int              DRAIN_CYCLES = 40;
    localparam int              CYCLE_LIMIT  = 400000;
    localparam int              RANDOM_WORDS = 1650;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              o_done;
    t_rsp              o_rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                errors;
    int                pending;
    int                cycles;
    logic [DATA_W-1:0] moduli [NUM_LANES];

    rns_modular_alu dut (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_done, .o_rsp,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rma_checker checker_i (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_req, .i_done(o_done),
        .i_rsp(o_rsp), .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** rns_modular_alu: FAILED **");
            $finish;
        end
    end

    task automatic write_modulus(input int lane, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(lane * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        moduli[lane] = value;
    endtask

    task automatic wait_idle;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_moduli(input logic [DATA_W-1:0] m0, input logic [DATA_W-1:0] m1,
                              input logic [DATA_W-1:0] m2, input logic [DATA_W-1:0] m3);
        wait_idle();
        write_modulus(0, m0);
        write_modulus(1, m1);
        write_modulus(2, m2);
        write_modulus(3, m3);
    endtask

    // hold start across back-to-back words; lower it only when a gap follows
    task automatic issue_word(input t_req req, input bit hold_after);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        if (!hold_after) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_residue(input int lane, input bit allow_bad);
        logic [DATA_W-1:0] m;
        m = moduli[lane];
        if (allow_bad && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
                0:       return m;
                1:       return DATA_W'('1);
                default: return m + $urandom_range(0, 3) < m ? DATA_W'('1) : m + $urandom_range(0, 3);
            endcase
        end
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return m - 1;
            default: return $urandom % m;
        endcase
    endfunction

    function automatic t_req random_word(input bit allow_bad);
        t_req req;
        int   sel;
        sel = $urandom_range(0, 19);
        req.req_type = (sel == 0) ? ($urandom_range(0, 1) ? OP_UNDEF_LO : OP_UNDEF_HI)
                                  : OP_W'($urandom_range(0, 5));
        req.a_lane0  = pick_residue(0, allow_bad);
        req.a_lane1  = pick_residue(1, allow_bad);
        req.a_lane2  = pick_residue(2, allow_bad);
        req.a_lane3  = pick_residue(3, allow_bad);
        req.b_lane0  = pick_residue(0, allow_bad);
        req.b_lane1  = pick_residue(1, allow_bad);
        req.b_lane2  = pick_residue(2, allow_bad);
        req.b_lane3  = pick_residue(3, allow_bad);
        case ($urandom_range(0, 5))
            0:       req.scalar = '0;
            1:       req.scalar = '1;
            2:       req.scalar = 64'd1;
            default: req.scalar = {$urandom, $urandom};
        endcase
        return req;
    endfunction

    function automatic t_req edge_word(input logic [OP_W-1:0] op, input int kind,
                                       input logic [SCALAR_W-1:0] s);
        t_req req;
        logic [DATA_W-1:0] v [NUM_LANES];
        for (int i = 0; i < NUM_LANES; i++)
            v[i] = (kind == 0) ? '0 : (kind == 1) ? moduli[i] - 1 : moduli[i];
        req.req_type = op;
        {req.a_lane0, req.a_lane1, req.a_lane2, req.a_lane3} = {v[0], v[1], v[2], v[3]};
        {req.b_lane0, req.b_lane1, req.b_lane2, req.b_lane3} = {v[0], v[1], v[2], v[3]};
        req.scalar = s;
        return req;
    endfunction

    task automatic run_random(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++)
                issue_word(random_word(1'b1), k != burst - 1);
            left -= burst;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    initial begin
        t_req req;
        cycles  = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        for (int i = 0; i < NUM_LANES; i++) moduli[i] = RESET_MODULI[i];
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every operation at the residue extremes and the scalar extremes
        for (int op = 0; op <= 5; op++) begin
            issue_word(edge_word(OP_W'(op), 0, '0), 1'b0);
            issue_word(edge_word(OP_W'(op), 1, '1), 1'b1);
            issue_word(edge_word(OP_W'(op), 2, 64'd1), 1'b0);
        end
        req = edge_word(OP_ADDS, 1, 64'd1);
        req.b_lane2 = '1;
        issue_word(req, 1'b0);
        issue_word(edge_word(OP_UNDEF_LO, 2, '1), 1'b1);
        issue_word(edge_word(OP_UNDEF_HI, 1, '1), 1'b0);

        run_random(RANDOM_WORDS / 5);
        set_moduli(32'd2, 32'd3, 32'd5, 32'd7);
        run_random(RANDOM_WORDS / 5);
        // let the pipeline empty before carrying on
        while (pending != 0) @(posedge i_clk);
        run_random(40);
        set_moduli('1, 32'd4294967294, 32'd4294967293, 32'd4294967291);
        run_random(RANDOM_WORDS / 5);
        set_moduli($urandom_range(2, 65535), $urandom_range(2, 65535),
                   $urandom_range(2, 65535), $urandom_range(2, 65535));
        run_random(RANDOM_WORDS / 5);
        set_moduli($urandom | 32'h8000_0000, $urandom | 32'd2, $urandom_range(2, 1000),
                   $urandom | 32'h1);
        run_random(RANDOM_WORDS / 5 - 40);

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("** rns_modular_alu: PASSED **");
        end else begin
            $display("** rns_modular_alu: FAILED **");
        end
        $finish;
    end
endmodule
